// ===== rtl/shn_pkg.sv =====
package shn_pkg;

   // Configuration register widths and reset values.
   localparam int DIM_W     = 12;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 12'd256;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_STRENGTH_GAIN = 2'd2
   } csr_index_type;

   // Operation codes carried on req_tuser.
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int MAX_WIDTH_DEFAULT   = 2048;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // z = 1 in gradient units is 2^(Z_SHIFT + sample bits).
   localparam int Z_SHIFT = 11;

   // Normalized vector path.
   localparam int NORM_W = 30;
   localparam int SQ_W   = 62;
   localparam int ROOT_W = 31;
   localparam int Q_W    = 16;
   localparam int LANES  = 3;

   // Result fields.
   localparam int OUT_W       = 16;
   localparam int Z_W         = 15;
   localparam int RSP_FIELD_W = 2 * OUT_W + Z_W;
   localparam int RSP_DATA_W  = 48;

   localparam logic [Q_W-1:0] Q15_MAX = 16'd32767;

endpackage

// ===== rtl/shn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module shn_sqrt #(
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [shn_pkg::SQ_W-1:0]    in_value,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [shn_pkg::ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int RN = shn_pkg::ROOT_W;
   localparam int VW = shn_pkg::SQ_W;
   localparam int RW = RN + 2;
   localparam int SW = RW + 2;

   logic [RW-1:0]    rem_ff  [0:RN-2];
   logic [VW-1:0]    val_ff  [0:RN-2];
   logic [RN-1:0]    root_ff [0:RN-1];
   logic [TAG_W-1:0] tag_ff  [0:RN-1];
   logic             vld_ff  [0:RN-1];

   for (genvar s = 0; s < RN; s++) begin : g_stage
      logic [RW-1:0]    rem_src;
      logic [VW-1:0]    val_src;
      logic [RN-1:0]    root_src;
      logic [TAG_W-1:0] tag_src;
      logic             vld_src;
      logic [SW-1:0]    rem_sh;
      logic [SW-1:0]    trial;
      logic [RW-1:0]    rem_in;
      logic [RN-1:0]    root_in;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign val_src  = in_value;
         assign root_src = '0;
         assign tag_src  = in_tag;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign val_src  = val_ff[s-1];
         assign root_src = root_ff[s-1];
         assign tag_src  = tag_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      always_comb begin
         rem_sh = {rem_src, val_src[VW-1 -: 2]};
         trial  = {2'b00, root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = RW'(rem_sh - trial);
            root_in = {root_src[RN-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW-1:0];
            root_in = {root_src[RN-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
         if (en) begin
            root_ff[s] <= root_in;
            tag_ff[s]  <= tag_src;
         end
      end

      if (s < RN - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               val_ff[s] <= {val_src[VW-3:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = vld_ff[RN-1];
   assign out_root  = root_ff[RN-1];
   assign out_tag   = tag_ff[RN-1];

endmodule

// ===== rtl/shn_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// Each lane forms (num << (Q_W-1)) / den, with num <= den.
module shn_div #(
   parameter int TAG_W = 1
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               en,
   input  logic                                               in_valid,
   input  logic [shn_pkg::LANES-1:0][shn_pkg::NORM_W-1:0]     in_num,
   input  logic [shn_pkg::ROOT_W-1:0]                         in_den,
   input  logic [TAG_W-1:0]                                   in_tag,
   output logic                                               out_valid,
   output logic [shn_pkg::LANES-1:0][shn_pkg::Q_W-1:0]        out_quot,
   output logic [TAG_W-1:0]                                   out_tag
);

   localparam int L  = shn_pkg::LANES;
   localparam int NW = shn_pkg::NORM_W;
   localparam int DW = shn_pkg::ROOT_W;
   localparam int QW = shn_pkg::Q_W;
   localparam int XW = NW + QW - 1;

   logic [L-1:0][DW-1:0] rem_ff  [0:QW-2];
   logic [L-1:0][QW-1:0] low_ff  [0:QW-2];
   logic [DW-1:0]        den_ff  [0:QW-2];
   logic [L-1:0][QW-1:0] quot_ff [0:QW-1];
   logic [TAG_W-1:0]     tag_ff  [0:QW-1];
   logic                 vld_ff  [0:QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [L-1:0][DW-1:0] rem_src;
      logic [L-1:0][QW-1:0] low_src;
      logic [L-1:0][QW-1:0] quot_src;
      logic [DW-1:0]        den_src;
      logic [TAG_W-1:0]     tag_src;
      logic                 vld_src;
      logic [L-1:0][DW-1:0] rem_in;
      logic [L-1:0][QW-1:0] low_in;
      logic [L-1:0][QW-1:0] quot_in;

      if (s == 0) begin : g_first
         for (genvar l = 0; l < L; l++) begin : g_lane
            logic [XW-1:0] ext;
            assign ext         = {in_num[l], {(QW-1){1'b0}}};
            assign rem_src[l]  = DW'(ext[XW-1:QW]);
            assign low_src[l]  = ext[QW-1:0];
            assign quot_src[l] = '0;
         end
         assign den_src = in_den;
         assign tag_src = in_tag;
         assign vld_src = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign low_src  = low_ff[s-1];
         assign quot_src = quot_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign tag_src  = tag_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      always_comb begin
         logic [DW:0] rem_sh;
         for (int l = 0; l < L; l++) begin
            rem_sh    = {rem_src[l], low_src[l][QW-1]};
            low_in[l] = {low_src[l][QW-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_src}) begin
               rem_in[l]  = DW'(rem_sh - {1'b0, den_src});
               quot_in[l] = {quot_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l]  = rem_sh[DW-1:0];
               quot_in[l] = {quot_src[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
         if (en) begin
            quot_ff[s] <= quot_in;
            tag_ff[s]  <= tag_src;
         end
      end

      if (s < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               low_ff[s] <= low_in;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

// ===== rtl/sobel_height_to_normal.sv =====
// A normal is offered on rsp after the req word that completes its neighborhood is accepted
// and crosses the pipeline; that word arrives width+1 words after the pixel's own sample.
// Throughput: one word per cycle while the skid register is empty, set by a fully pipelined
// datapath (two-stage multiplies, a 31-stage square root, a 16-stage three-lane divider).
// Reset (synchronous, active high) restores the register defaults, clears the counters, the
// window and every valid bit; the line buffers are not cleared.
module sobel_height_to_normal #(
   parameter int  MAX_WIDTH   = shn_pkg::MAX_WIDTH_DEFAULT,
   parameter int  SAMPLE_BITS = shn_pkg::SAMPLE_BITS_DEFAULT,
   localparam int REQ_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request words.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_DATA_W-1:0]              req_tdata,   // height_sample
   input  logic                               req_tuser,   // operation
   // Response words.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [shn_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // normal_x, normal_y, normal_z
   output logic                               rsp_tlast,   // frame_end
   // Register writes.
   input  logic                               csr_we,
   input  logic [shn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [shn_pkg::GAIN_W-1:0]         csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int DIM_W = shn_pkg::DIM_W;
   localparam int NW    = shn_pkg::NORM_W;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CMPW  = ((AW > DIM_W) ? AW : DIM_W) + 1;
   localparam int SAW   = SB + 2;                      // magnitude of a Sobel sum
   localparam int SXW   = SB + 3;                      // signed Sobel sum
   localparam int PXW   = SAW + DIM_W;
   localparam int UAW   = PXW + shn_pkg::GAIN_W;
   localparam int HW    = UAW - NW;
   localparam int KW    = $clog2(HW + 1);
   localparam logic [UAW-1:0] UD = {{(UAW-1){1'b0}}, 1'b1} << (shn_pkg::Z_SHIFT + SB);

   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
      logic last;
   } edge_flags_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic last;
   } sign_tag_type;

   typedef struct packed {
      logic [NW-1:0] a;
      logic [NW-1:0] b;
      logic [NW-1:0] d;
      sign_tag_type  sg;
   } root_tag_type;

   // ------------------------------------------------------------------
   // Configuration registers. Writing either dimension restarts the frame.
   // ------------------------------------------------------------------
   logic [DIM_W-1:0]           img_w_ff;
   logic [DIM_W-1:0]           img_h_ff;
   logic [shn_pkg::GAIN_W-1:0] gain_ff;
   logic                       dim_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= shn_pkg::DIM_RESET;
         img_h_ff <= shn_pkg::DIM_RESET;
         gain_ff  <= shn_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            shn_pkg::CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata[DIM_W-1:0];
            shn_pkg::CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata[DIM_W-1:0];
            shn_pkg::CSR_STRENGTH_GAIN: gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dim_write = csr_we && (csr_index == shn_pkg::CSR_IMAGE_WIDTH ||
                                 csr_index == shn_pkg::CSR_IMAGE_HEIGHT);

   // A zero dimension acts as one, and a width beyond the line buffers is clamped.
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;

   always_comb begin
      if (img_w_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(img_w_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = img_w_ff;
      end
      h_eff = (img_h_ff == '0) ? DIM_W'(1) : img_h_ff;
   end

   // ------------------------------------------------------------------
   // Pipeline enable. The whole datapath moves together and only stops when
   // the skid register is holding a second finished word.
   // ------------------------------------------------------------------
   logic en;
   logic skid_v_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   // ------------------------------------------------------------------
   // Stage 0: raster counters. col/row track the input position, ox/oy track
   // the pixel whose normal is produced next. Once row reaches the height the
   // frame is draining and each word shifts in a zero sample.
   // ------------------------------------------------------------------
   logic [AW-1:0]    col_ff;
   logic [DIM_W:0]   row_ff;
   logic [AW-1:0]    ox_ff;
   logic [DIM_W-1:0] oy_ff;

   logic          accept;
   logic          draining;
   logic          proc;
   logic          produce;
   logic          col_wrap;
   logic          ox_last;
   logic          oy_last;
   logic          frame_last;
   logic [SB-1:0] sample;

   assign accept   = req_tvalid && en;
   assign draining = row_ff >= (DIM_W+1)'(h_eff);
   // A drain word that arrives while samples are still expected is dropped.
   assign proc     = accept && !(req_tuser == shn_pkg::OP_DRAIN && !draining);
   assign sample   = draining ? '0 : req_tdata[SB-1:0];
   // The first width+1 words only fill the window.
   assign produce  = !(row_ff == '0 || (row_ff == (DIM_W+1)'(1) && col_ff == '0));
   assign col_wrap = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(w_eff);
   assign ox_last  = (CMPW'(ox_ff) + CMPW'(1)) == CMPW'(w_eff);
   assign oy_last  = ((DIM_W+1)'(oy_ff) + (DIM_W+1)'(1)) == (DIM_W+1)'(h_eff);
   assign frame_last = produce && ox_last && oy_last;

   always_ff @(posedge clock) begin
      if (reset || dim_write) begin
         col_ff <= '0;
         row_ff <= '0;
         ox_ff  <= '0;
         oy_ff  <= '0;
      end else if (proc) begin
         if (frame_last) begin
            col_ff <= '0;
            row_ff <= '0;
            ox_ff  <= '0;
            oy_ff  <= '0;
         end else begin
            if (col_wrap) begin
               col_ff <= '0;
               row_ff <= row_ff + (DIM_W+1)'(1);
            end else begin
               col_ff <= col_ff + AW'(1);
            end
            if (produce) begin
               if (ox_last) begin
                  ox_ff <= '0;
                  oy_ff <= oy_ff + DIM_W'(1);
               end else begin
                  ox_ff <= ox_ff + AW'(1);
               end
            end
         end
      end
   end

   // Line buffers: line_mid holds the previous row, line_top the one before.
   // Both are read and rewritten at the current column in the same cycle.
   logic [SB-1:0] line_mid_ff [0:MAX_WIDTH-1];
   logic [SB-1:0] line_top_ff [0:MAX_WIDTH-1];
   logic [SB-1:0] top_rd_ff;
   logic [SB-1:0] mid_rd_ff;

   always_ff @(posedge clock) begin
      if (proc) begin
         top_rd_ff           <= line_top_ff[col_ff];
         mid_rd_ff           <= line_mid_ff[col_ff];
         line_top_ff[col_ff] <= line_mid_ff[col_ff];
         line_mid_ff[col_ff] <= sample;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line buffer data and edge flags of the pixel to be produced.
   // ------------------------------------------------------------------
   logic           s1_v_ff;
   logic           s1_prod_ff;
   edge_flags_type s1_fl_ff;
   logic [SB-1:0]  s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= proc;
      end
      if (en) begin
         s1_prod_ff       <= produce;
         s1_fl_ff.left    <= ox_ff == '0;
         s1_fl_ff.right   <= ox_last;
         s1_fl_ff.top     <= oy_ff == '0;
         s1_fl_ff.bottom  <= oy_last;
         s1_fl_ff.last    <= frame_last;
         s1_sample_ff     <= sample;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: the 3x3 window shifts left; the new column enters on the right.
   // Row 0 is the oldest row, column 2 the newest sample.
   // ------------------------------------------------------------------
   logic [SB-1:0]  win_ff [0:2][0:2];
   logic           s2_v_ff;
   edge_flags_type s2_fl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (en && s1_v_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= top_rd_ff;
         win_ff[1][2] <= mid_rd_ff;
         win_ff[2][2] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff && s1_prod_ff;
      end
      if (en) begin
         s2_fl_ff <= s1_fl_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: Sobel sums. At an image border the missing neighbor is replaced
   // by the center row or column, which is the clamped-edge rule.
   // ------------------------------------------------------------------
   logic [SB-1:0]  lcol [0:2];
   logic [SB-1:0]  rcol [0:2];
   logic [SB-1:0]  trow [0:2];
   logic [SB-1:0]  brow [0:2];
   logic [SXW-1:0] sx_pos, sx_neg, sy_pos, sy_neg;
   logic signed [SXW-1:0] sx, sy;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lcol[r] = s2_fl_ff.left  ? win_ff[r][1] : win_ff[r][0];
         rcol[r] = s2_fl_ff.right ? win_ff[r][1] : win_ff[r][2];
      end
      for (int c = 0; c < 3; c++) begin
         trow[c] = s2_fl_ff.top    ? win_ff[1][c] : win_ff[0][c];
         brow[c] = s2_fl_ff.bottom ? win_ff[1][c] : win_ff[2][c];
      end
      sx_pos = SXW'(s2_fl_ff.top ? rcol[1] : rcol[0]) + (SXW'(rcol[1]) << 1)
             + SXW'(s2_fl_ff.bottom ? rcol[1] : rcol[2]);
      sx_neg = SXW'(s2_fl_ff.top ? lcol[1] : lcol[0]) + (SXW'(lcol[1]) << 1)
             + SXW'(s2_fl_ff.bottom ? lcol[1] : lcol[2]);
      sy_pos = SXW'(s2_fl_ff.left ? brow[1] : brow[0]) + (SXW'(brow[1]) << 1)
             + SXW'(s2_fl_ff.right ? brow[1] : brow[2]);
      sy_neg = SXW'(s2_fl_ff.left ? trow[1] : trow[0]) + (SXW'(trow[1]) << 1)
             + SXW'(s2_fl_ff.right ? trow[1] : trow[2]);
      sx = $signed(sx_pos - sx_neg);
      sy = $signed(sy_pos - sy_neg);
   end

   logic         s3_v_ff;
   logic [SAW-1:0] s3_ax_ff, s3_ay_ff;
   sign_tag_type s3_sg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s3_ax_ff       <= SAW'(sx[SXW-1] ? -sx : sx);
         s3_ay_ff       <= SAW'(sy[SXW-1] ? -sy : sy);
         // The normal points against the gradient, so a positive sum gives a
         // negative component.
         s3_sg_ff.neg_x <= !sx[SXW-1] && (sx != '0);
         s3_sg_ff.neg_y <= !sy[SXW-1] && (sy != '0);
         s3_sg_ff.last  <= s2_fl_ff.last;
      end
   end

   // ------------------------------------------------------------------
   // Stages 4 and 5: scale by the image size, then by the strength.
   // ------------------------------------------------------------------
   logic         s4_v_ff;
   logic [PXW-1:0] s4_px_ff, s4_py_ff;
   sign_tag_type s4_sg_ff;
   logic         s5_v_ff;
   logic [UAW-1:0] s5_ua_ff, s5_ub_ff;
   sign_tag_type s5_sg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
      if (en) begin
         s4_px_ff <= PXW'(s3_ax_ff * w_eff);
         s4_py_ff <= PXW'(s3_ay_ff * h_eff);
         s4_sg_ff <= s3_sg_ff;
         s5_ua_ff <= UAW'(s4_px_ff * gain_ff);
         s5_ub_ff <= UAW'(s4_py_ff * gain_ff);
         s5_sg_ff <= s4_sg_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: the shift that brings the largest magnitude below 2^30 is the
   // bit length of bits 30 and above of the OR of the three values.
   // ------------------------------------------------------------------
   logic [UAW-1:0] mag_or;
   logic [HW-1:0]  mag_hi;
   logic [KW-1:0]  shift_k;

   always_comb begin
      mag_or  = s5_ua_ff | s5_ub_ff | UD;
      mag_hi  = mag_or[UAW-1:NW];
      shift_k = '0;
      for (int i = 0; i < HW; i++) begin
         if (mag_hi[i]) begin
            shift_k = KW'(i + 1);
         end
      end
   end

   logic         s6_v_ff;
   logic [KW-1:0] s6_k_ff;
   logic [UAW-1:0] s6_ua_ff, s6_ub_ff;
   sign_tag_type s6_sg_ff;

   // Stage 7: the three components after the common right shift.
   logic         s7_v_ff;
   logic [NW-1:0] s7_a_ff, s7_b_ff, s7_d_ff;
   sign_tag_type s7_sg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
      if (en) begin
         s6_k_ff  <= shift_k;
         s6_ua_ff <= s5_ua_ff;
         s6_ub_ff <= s5_ub_ff;
         s6_sg_ff <= s5_sg_ff;
         s7_a_ff  <= NW'(s6_ua_ff >> s6_k_ff);
         s7_b_ff  <= NW'(s6_ub_ff >> s6_k_ff);
         s7_d_ff  <= NW'(UD >> s6_k_ff);
         s7_sg_ff <= s6_sg_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stages 8 and 9: squares, then their sum.
   // ------------------------------------------------------------------
   logic           s8_v_ff;
   logic [2*NW-1:0] s8_sa_ff, s8_sb_ff, s8_sd_ff;
   root_tag_type   s8_tag_ff;
   logic           s9_v_ff;
   logic [shn_pkg::SQ_W-1:0] s9_sum_ff;
   root_tag_type   s9_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
         s9_v_ff <= 1'b0;
      end else if (en) begin
         s8_v_ff <= s7_v_ff;
         s9_v_ff <= s8_v_ff;
      end
      if (en) begin
         s8_sa_ff     <= s7_a_ff * s7_a_ff;
         s8_sb_ff     <= s7_b_ff * s7_b_ff;
         s8_sd_ff     <= s7_d_ff * s7_d_ff;
         s8_tag_ff.a  <= s7_a_ff;
         s8_tag_ff.b  <= s7_b_ff;
         s8_tag_ff.d  <= s7_d_ff;
         s8_tag_ff.sg <= s7_sg_ff;
         s9_sum_ff    <= shn_pkg::SQ_W'(s8_sa_ff) + shn_pkg::SQ_W'(s8_sb_ff)
                       + shn_pkg::SQ_W'(s8_sd_ff);
         s9_tag_ff    <= s8_tag_ff;
      end
   end

   // ------------------------------------------------------------------
   // Vector length, then each component divided by it. z is never zero, so
   // the length is never zero either.
   // ------------------------------------------------------------------
   logic                                       rt_v;
   logic [shn_pkg::ROOT_W-1:0]                 rt_len;
   root_tag_type                               rt_tag;
   logic [shn_pkg::LANES-1:0][NW-1:0]          dv_num;
   logic                                       dv_v;
   logic [shn_pkg::LANES-1:0][shn_pkg::Q_W-1:0] dv_quot;
   sign_tag_type                               dv_sg;

   shn_sqrt #(
      .TAG_W     ($bits(root_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s9_v_ff),
      .in_value  (s9_sum_ff),
      .in_tag    (s9_tag_ff),
      .out_valid (rt_v),
      .out_root  (rt_len),
      .out_tag   (rt_tag)
   );

   assign dv_num = {rt_tag.d, rt_tag.b, rt_tag.a};

   shn_div #(
      .TAG_W     ($bits(sign_tag_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_v),
      .in_num    (dv_num),
      .in_den    (rt_len),
      .in_tag    (rt_tag.sg),
      .out_valid (dv_v),
      .out_quot  (dv_quot),
      .out_tag   (dv_sg)
   );

   // Saturation to Q1.15. The quotient never exceeds 32768, which only the
   // negative side can represent.
   logic [shn_pkg::OUT_W-1:0]       nx, ny;
   logic [shn_pkg::Z_W-1:0]         nz;
   logic [shn_pkg::RSP_FIELD_W-1:0] res_fields;

   always_comb begin
      if (dv_sg.neg_x) begin
         nx = shn_pkg::OUT_W'(~dv_quot[0] + shn_pkg::Q_W'(1));
      end else begin
         nx = (dv_quot[0] > shn_pkg::Q15_MAX) ? shn_pkg::Q15_MAX : dv_quot[0];
      end
      if (dv_sg.neg_y) begin
         ny = shn_pkg::OUT_W'(~dv_quot[1] + shn_pkg::Q_W'(1));
      end else begin
         ny = (dv_quot[1] > shn_pkg::Q15_MAX) ? shn_pkg::Q15_MAX : dv_quot[1];
      end
      nz = shn_pkg::Z_W'((dv_quot[2] > shn_pkg::Q15_MAX) ? shn_pkg::Q15_MAX : dv_quot[2]);
      res_fields = {nz, ny, nx};
   end

   // ------------------------------------------------------------------
   // Output register with a skid register behind it. A word leaving the
   // pipeline goes to the output register when it is free, otherwise to the
   // skid register, which then freezes the pipeline until it drains.
   // ------------------------------------------------------------------
   logic                            out_v_ff;
   logic [shn_pkg::RSP_FIELD_W-1:0] out_data_ff;
   logic                            out_last_ff;
   logic [shn_pkg::RSP_FIELD_W-1:0] skid_data_ff;
   logic                            skid_last_ff;
   logic                            out_free;

   assign out_free = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || dv_v;
         skid_v_ff <= 1'b0;
      end else if (dv_v && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_v_ff ? skid_data_ff : res_fields;
         out_last_ff <= skid_v_ff ? skid_last_ff : dv_sg.last;
      end else if (dv_v && en) begin
         skid_data_ff <= res_fields;
         skid_last_ff <= dv_sg.last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(shn_pkg::RSP_DATA_W-shn_pkg::RSP_FIELD_W){1'b0}}, out_data_ff};
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds a word while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_tready) |=> (skid_v_ff && $stable(skid_data_ff)))
      else $error("skid word lost while the response side stalls");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (CMPW'(col_ff) < CMPW'(w_eff)) && (CMPW'(ox_ff) < CMPW'(w_eff)))
      else $error("column counter beyond the image width");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (proc && frame_last) |=> (col_ff == '0 && row_ff == '0 && ox_ff == '0 && oy_ff == '0))
      else $error("counters not cleared after the last normal of a frame");

endmodule

// ===== test/shn_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports of the normal-map block,
// predicts every normal and compares it with what the block returns.
module shn_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [shn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [shn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [shn_pkg::GAIN_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   localparam int LINE_LEN = shn_pkg::MAX_WIDTH_DEFAULT;

   typedef struct packed {
      logic [shn_pkg::OUT_W-1:0] nx;
      logic [shn_pkg::OUT_W-1:0] ny;
      logic [shn_pkg::Z_W-1:0]   nz;
      logic                      fe;
   } normal_type;

   normal_type       normal_queue[$];
   logic [15:0]      line_buf[2][LINE_LEN];
   int unsigned      win[3][3];
   int unsigned      width_reg, height_reg, gain_reg;
   int unsigned      col_cnt, row_cnt, out_cnt;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_q15(longint unsigned mag, bit neg,
                                             longint unsigned len);
      longint unsigned q;
      q = (mag << 15) / len;
      if (neg) return (q > 32768) ? 16'h8000 : 16'(~q + 1);
      return (q > 32767) ? 16'h7fff : 16'(q);
   endfunction

   task automatic clear_state();
      width_reg  = shn_pkg::DIM_RESET;
      height_reg = shn_pkg::DIM_RESET;
      gain_reg   = shn_pkg::GAIN_RESET;
      col_cnt = 0;
      row_cnt = 0;
      out_cnt = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = 0;
      for (int i = 0; i < LINE_LEN; i++) begin
         line_buf[0][i] = 0;
         line_buf[1][i] = 0;
      end
      normal_queue.delete();
   endtask

   // Advances the predicted window by one request word and queues a normal
   // once the window around the next output pixel is complete.
   task automatic predict_normal(logic op, logic [15:0] smp);
      int unsigned      w, h, total, item, s, t, m, ox, oy, cl, cr, rt, rb;
      bit               draining;
      longint           sx, sy;
      longint unsigned  ua, ub, ud, mx, len;
      normal_type       n;
      w = (width_reg == 0) ? 1 : (width_reg > LINE_LEN) ? LINE_LEN : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      total = w * h;
      item = row_cnt * w + col_cnt;
      draining = item >= total;
      if (op == shn_pkg::OP_DRAIN && !draining) return;
      s = draining ? 0 : smp;
      t = line_buf[1][col_cnt];
      m = line_buf[0][col_cnt];
      line_buf[1][col_cnt] = m;
      line_buf[0][col_cnt] = s;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = s;
      col_cnt++;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
      end
      if (item < w + 1) return;

      ox = out_cnt % w;
      oy = out_cnt / w;
      cl = (ox == 0) ? 1 : 0;
      cr = (ox == w - 1) ? 1 : 2;
      rt = (oy == 0) ? 1 : 0;
      rb = (oy >= h - 1) ? 1 : 2;
      sx = longint'(win[rt][cr]) + 2 * longint'(win[1][cr]) + longint'(win[rb][cr])
         - longint'(win[rt][cl]) - 2 * longint'(win[1][cl]) - longint'(win[rb][cl]);
      sy = longint'(win[rb][cl]) + 2 * longint'(win[rb][1]) + longint'(win[rb][cr])
         - longint'(win[rt][cl]) - 2 * longint'(win[rt][1]) - longint'(win[rt][cr]);
      ua = longint'(sx < 0 ? -sx : sx) * w * gain_reg;
      ub = longint'(sy < 0 ? -sy : sy) * h * gain_reg;
      ud = 64'd1 << (shn_pkg::Z_SHIFT + shn_pkg::SAMPLE_BITS_DEFAULT);
      mx = (ua > ub) ? ua : ub;
      if (ud > mx) mx = ud;
      // Scale all three lanes together until the largest fits in 30 bits.
      while (mx >= (64'd1 << shn_pkg::NORM_W)) begin
         mx = mx >> 1;
         ua = ua >> 1;
         ub = ub >> 1;
         ud = ud >> 1;
      end
      len = int_sqrt(ua * ua + ub * ub + ud * ud);
      if (len == 0) begin
         n.nx = 0;
         n.ny = 0;
         n.nz = shn_pkg::Q15_MAX[shn_pkg::Z_W-1:0];
      end else begin
         n.nx = scale_q15(ua, sx > 0, len);
         n.ny = scale_q15(ub, sy > 0, len);
         n.nz = shn_pkg::Z_W'(scale_q15(ud, 1'b0, len));
      end
      out_cnt++;
      n.fe = out_cnt >= total;
      if (n.fe) begin
         col_cnt = 0;
         row_cnt = 0;
         out_cnt = 0;
      end
      normal_queue.insert(normal_queue.size(), n);
   endtask

   task automatic compare_normal();
      normal_type e;
      if (normal_queue.size() == 0) begin
         $error("unexpected normal word %h", rsp_tdata);
         fail_count++;
         return;
      end
      e = normal_queue.pop_front();
      if (rsp_tdata[15:0] !== e.nx) begin
         $error("normal_x expected %0d actual %0d", $signed(e.nx), $signed(rsp_tdata[15:0]));
         fail_count++;
      end
      if (rsp_tdata[31:16] !== e.ny) begin
         $error("normal_y expected %0d actual %0d", $signed(e.ny), $signed(rsp_tdata[31:16]));
         fail_count++;
      end
      if (rsp_tdata[46:32] !== e.nz) begin
         $error("normal_z expected %0d actual %0d", e.nz, rsp_tdata[46:32]);
         fail_count++;
      end
      if (rsp_tlast !== e.fe) begin
         $error("frame_end expected %0d actual %0d", e.fe, rsp_tlast);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               shn_pkg::CSR_IMAGE_WIDTH: width_reg = csr_wdata[shn_pkg::DIM_W-1:0];
               shn_pkg::CSR_IMAGE_HEIGHT: height_reg = csr_wdata[shn_pkg::DIM_W-1:0];
               shn_pkg::CSR_STRENGTH_GAIN: gain_reg = csr_wdata;
               default: ;
            endcase
            if (csr_index == shn_pkg::CSR_IMAGE_WIDTH ||
                csr_index == shn_pkg::CSR_IMAGE_HEIGHT) begin
               col_cnt = 0;
               row_cnt = 0;
               out_cnt = 0;
            end
         end
         if (req_tvalid && req_tready) predict_normal(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) compare_normal();
      end
      pending = normal_queue.size();
   end

endmodule

// ===== test/tb_sobel_height_to_normal.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the height-to-normal block. The checker beside the
// block does all prediction and comparison; this module only drives words.
module tb_sobel_height_to_normal;

   // Settling wait that lets a word still in the pipeline finish.
   localparam int SETTLE_CYCLES = 72;
   localparam int CYCLE_LIMIT   = 900000;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [15:0]                    req_tdata;   // height_sample
   logic                           req_tuser;   // operation
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [shn_pkg::RSP_DATA_W-1:0] rsp_tdata;   // normal_x, normal_y, normal_z
   logic                           rsp_tlast;   // frame_end
   logic                           csr_we;
   logic [shn_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [shn_pkg::GAIN_W-1:0]     csr_wdata;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int send_idle_pct;
   int recv_stall_pct;
   int words_sent;
   int frames_run;

   sobel_height_to_normal u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   shn_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sobel_height_to_normal verification failed");
         $finish;
      end
   end

   // The receiver drops its ready at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Presents one word at a falling edge and holds it until it is accepted.
   // Random gaps are inserted ahead of the word while the sender is idle.
   task automatic send_word(logic op, logic [15:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
   endtask

   // Wait for every predicted normal, then leave the pipeline time to finish
   // any word that produces no normal, so a register write lands on an idle block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all three registers on consecutive cycles.
   task automatic write_regs(int unsigned w, int unsigned h, int unsigned gain);
      csr_we    <= 1'b1;
      csr_index <= shn_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= 16'(w);
      @(negedge clock);
      csr_index <= shn_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= 16'(h);
      @(negedge clock);
      csr_index <= shn_pkg::CSR_STRENGTH_GAIN;
      csr_wdata <= 16'(gain);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Height samples lean toward the two extremes so that steep gradients
   // and saturation show up often.
   function automatic logic [15:0] pick_sample(int pattern, int idx);
      int r;
      if (pattern == 1) return (idx % 2 == 0) ? 16'h0000 : 16'hffff;
      r = $urandom_range(7);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hffff;
      return 16'($urandom);
   endfunction

   // Runs one whole frame: a register setup, the raster of samples with the
   // odd ignored early drain mixed in, and a flush of width+1 words in which
   // some drains are replaced by late pushes, which the block treats as drains.
   task automatic run_frame(int unsigned w, int unsigned h, int unsigned gain,
                            int mode, int pattern);
      int unsigned ew, eh;
      ew = (w == 0) ? 1 : (w > shn_pkg::MAX_WIDTH_DEFAULT) ? shn_pkg::MAX_WIDTH_DEFAULT : w;
      eh = (h == 0) ? 1 : h;
      wait_idle();
      write_regs(w, h, gain);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < ew * eh; i++) begin
         if ($urandom_range(39) == 0) send_word(shn_pkg::OP_DRAIN, 16'($urandom));
         send_word(shn_pkg::OP_PUSH, pick_sample(pattern, i));
      end
      for (int j = 0; j <= ew; j++) begin
         if ($urandom_range(3) == 0) send_word(shn_pkg::OP_PUSH, 16'($urandom));
         else send_word(shn_pkg::OP_DRAIN, 16'($urandom));
      end
      // A trailing drain after the frame has flushed is ignored.
      if ($urandom_range(3) == 0) send_word(shn_pkg::OP_DRAIN, 16'hffff);
      frames_run++;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = shn_pkg::OP_PUSH;
      csr_we      = 1'b0;
      csr_index   = shn_pkg::CSR_IMAGE_WIDTH;
      csr_wdata   = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      words_sent  = 0;
      frames_run  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames: the smallest image, zero and full gain, dimensions
      // of zero, a single row, a checkerboard of extreme heights, a wide
      // two-row raster and a tall single-column one.
      run_frame(1, 1, 0, 0, 0);
      run_frame(3, 2, 65535, 0, 1);
      run_frame(0, 0, 256, 3, 0);
      run_frame(4, 1, 256, 0, 1);
      run_frame(4, 3, 1, 2, 1);
      run_frame(100, 2, 65535, 0, 1);
      run_frame(1, 400, 32768, 0, 1);

      // Random frames, cycling through the four flow-control phases.
      for (int f = 0; words_sent < 1900; f++) begin
         run_frame($urandom_range(1, 12), $urandom_range(1, 8),
                   ($urandom_range(3) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 65535),
                   f % 4, ($urandom_range(5) == 0) ? 1 : 0);
      end

      wait_idle();
      $display("Covered %0d frames and %0d request words over %0d cycles.",
               frames_run, words_sent, cycle_count);
      $display("Phases mixed free flow, sparse sending, heavy back-pressure and light jitter.");
      if (fail_count == 0) begin
         $display("sobel_height_to_normal verification clean");
      end else begin
         $display("sobel_height_to_normal verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/shn_pkg.sv
rtl/shn_sqrt.sv
rtl/shn_div.sv
rtl/sobel_height_to_normal.sv
test/shn_checker.sv
test/tb_sobel_height_to_normal.sv
